// ===== hdl/epoch_millis_to_iso8601_text_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the epoch-to-ISO-8601 formatter
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef EPOCH_MILLIS_TO_ISO8601_TEXT_MACROS_SVH
`define EPOCH_MILLIS_TO_ISO8601_TEXT_MACROS_SVH

`ifndef SYNTHESIS

// implication check, sampled on the rising clock edge
`define E2I_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("e2i check failed");

// condition that must never be seen
`define E2I_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("e2i check failed");

`else

`define E2I_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define E2I_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== hdl/e2i_pkg.sv =====
// ----------------------------------------------------------------------------
// e2i_pkg
// Types, constants and helper functions of the epoch-to-ISO-8601 formatter.
// ----------------------------------------------------------------------------
package e2i_pkg;

	localparam int MILLIS_W  = 48;
	localparam int WORD_W    = 64;

	// queue between front and back
	localparam int MID_DEPTH = 4;
	localparam int MID_AW    = 2;

	// result queue, also the credit limit of the back pipeline
	localparam int OUT_DEPTH = 32;
	localparam int OUT_AW    = 5;

	// back datapath stages
	localparam int NSTAGE    = 19;

	localparam logic [47:0] LAST_MILLIS_9999 = 48'd253402300799999;

	// calendar constants
	localparam logic [21:0] DAYS_SHIFT    = 22'd719468;
	localparam logic [21:0] DAYS_PER_ERA  = 22'd146097;
	localparam logic [17:0] DOE_LAST      = 18'd146096;

	// reciprocals for exact division by constants: floor(n * M / 2^k)
	localparam logic [21:0] M_DIV125_HI = 22'd2147484;     // k = 28
	localparam logic [31:0] M_DIV125_LO = 32'd2199023256;  // k = 38
	localparam logic [31:0] M_DIV675    = 32'd3257812231;  // k = 41
	localparam logic [10:0] M_DIV100_MS = 11'd1311;        // k = 17
	localparam logic [17:0] M_DIV3600   = 18'd149131;      // k = 29
	localparam logic [22:0] M_DIV_ERA   = 23'd7525902;     // k = 40
	localparam logic [12:0] M_DIV60     = 13'd4370;        // k = 18
	localparam logic [18:0] M_DIV1460   = 19'd367720;      // k = 29
	localparam logic [18:0] M_DIV36524  = 19'd470373;      // k = 34
	localparam logic [18:0] M_DIV365    = 19'd367720;      // k = 27
	localparam logic [9:0]  M_DIV100_Y  = 10'd656;         // k = 16
	localparam logic [14:0] M_DIV100_YR = 15'd20972;       // k = 21
	localparam logic [11:0] M_DIV153    = 12'd3427;        // k = 19

	// ASCII codes
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_Z     = 8'h5A;

	typedef struct packed {
		logic [MILLIS_W-1:0] millis;
		logic                beyond;
	} e2i_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		logic              beyond;
	} e2i_result_t;

	typedef struct packed {
		logic [OUT_AW:0] credit_cnt;
		logic [OUT_AW:0] out_cnt;
	} e2i_stat_t;

	// binary (below 100) to two BCD digits, shift-add-3
	function automatic logic [7:0] to_bcd2(input logic [6:0] v);
		logic [14:0] sh;
		int i;
		sh = {8'd0, v};
		for (i = 0; i < 7; i++) begin
			if (sh[10:7] >= 4'd5) sh[10:7] = sh[10:7] + 4'd3;
			if (sh[14:11] >= 4'd5) sh[14:11] = sh[14:11] + 4'd3;
			sh = sh << 1;
		end
		return sh[14:7];
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return {4'h3, d};
	endfunction

	// first day-of-year of each March-based month
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/e2i_front.sv =====
// ----------------------------------------------------------------------------
// e2i_front
// Accepts input transactions, flags years past 9999, queues them for the back.
// ----------------------------------------------------------------------------
module e2i_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [e2i_pkg::MILLIS_W-1:0]    millis_since_epoch,
	output logic                            item_valid,
	output e2i_pkg::e2i_item_t              item,
	input  logic                            item_pop
);
	import e2i_pkg::*;

	e2i_item_t         mem_q [MID_DEPTH];
	logic [MID_AW-1:0] wr_ptr_q;
	logic [MID_AW-1:0] rd_ptr_q;
	logic [MID_AW:0]   cnt_q;
	logic              wr_en;
	logic              rd_en;

	assign full       = (cnt_q == (MID_AW+1)'(MID_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_pop && item_valid;

	// queue storage, classification on the way in
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= '{millis: millis_since_epoch,
				beyond: (millis_since_epoch > LAST_MILLIS_9999)};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/e2i_back.sv =====
// ----------------------------------------------------------------------------
// e2i_back
// Divider-free conversion pipeline and result queue with credit flow control.
// ----------------------------------------------------------------------------
module e2i_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  e2i_pkg::e2i_item_t   item,
	output logic                 item_pop,
	input  logic                 pop,
	output logic                 empty,
	output e2i_pkg::e2i_result_t result,
	output e2i_pkg::e2i_stat_t   stat
);
	import e2i_pkg::*;

	// time-of-day fields, filled in as the pipeline goes
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] sec;
		logic [3:0] mh;
		logic [6:0] ml;
		logic       beyond;
	} tod_t;

	logic [NSTAGE-1:0] vld_q;
	logic              issue;
	logic              deq;
	logic [OUT_AW:0]   credit_q;
	logic [OUT_AW:0]   out_cnt_q;
	logic [OUT_AW-1:0] out_wr_q;
	logic [OUT_AW-1:0] out_rd_q;
	e2i_result_t       out_mem_q [OUT_DEPTH];

	// stage registers
	logic [20:0] hi_s1;
	logic [23:0] lo_s1;
	logic [2:0]  m3_s1, m3_s2, m3_s3;
	logic [14:0] qhi_s1, qhi_s2, qhi_s3;
	logic        bey_s1, bey_s2, bey_s3, bey_s4, bey_s5;
	logic [30:0] x_s2, x_s3;
	logic [23:0] qlo_s3;
	logic [9:0]  msec_s4, msec_s5;
	logic [38:0] secs_s4;
	logic [21:0] days_s5;
	logic [31:0] n2_s5;
	logic [6:0]  s7_s5;
	logic [3:0]  mh_s5;
	logic [16:0] sod_s6, sod_s7;
	logic [21:0] z_s6, z_s7;
	logic [4:0]  era_s7, era_s8, era_s9, era_s10, era_s11, era_s12, era_s13, era_s14;
	logic [11:0] remh_s8, remh_s9;
	logic [17:0] doe_s8, doe_s9, doe_s10, doe_s11, doe_s12;
	logic [6:0]  q1_s9;
	logic [2:0]  q2_s9;
	logic        q3_s9;
	logic [17:0] yy_s10;
	logic [8:0]  yoe_s11, yoe_s12, yoe_s13, yoe_s14;
	logic [1:0]  y100_s12;
	logic [17:0] y365_s12;
	logic [8:0]  doy_s13, doy_s14;
	logic [3:0]  mp_s14;
	logic [4:0]  day_s15, day_s16, day_s17, day_s18;
	logic [3:0]  month_s15, month_s16, month_s17, month_s18;
	logic [13:0] year_s15;
	logic [13:0] yw_s16, yw_s17;
	logic [6:0]  yh_s17, yh_s18;
	logic [6:0]  yl_s18;
	tod_t        tod_s6, tod_s7, tod_s8, tod_s9, tod_s10, tod_s11, tod_s12, tod_s13;
	tod_t        tod_s14, tod_s15, tod_s16, tod_s17, tod_s18;
	e2i_result_t res_s19;

	// combinational pieces between stages
	logic [42:0] p_qhi;
	logic [20:0] t_rhi;
	logic [62:0] p_qlo;
	logic [30:0] t_r;
	logic [63:0] p_days;
	logic [20:0] p_mh;
	logic [31:0] t_sodh;
	logic [9:0]  t_ml;
	logic [34:0] p_hour;
	logic [44:0] p_era;
	logic [16:0] t_remh;
	logic [21:0] t_doe;
	logic [24:0] p_min;
	logic [36:0] p_q1;
	logic [36:0] p_q2;
	logic [11:0] t_sec;
	logic [36:0] p_yoe;
	logic [18:0] p_y100;
	logic [17:0] t_doy;
	logic [10:0] t_doy5;
	logic [22:0] p_mp;
	logic [8:0]  t_day;
	logic [3:0]  t_mon;
	logic [28:0] p_yh;
	logic [13:0] t_yl;
	logic [7:0]  bcd_mon, bcd_day, bcd_hr, bcd_min, bcd_sec, bcd_ms, bcd_yh, bcd_yl;

	// ms / 1000 as (ms >> 3) / 125, long division in a 21-bit high and a 24-bit low digit
	assign p_qhi  = 43'(item.millis[47:27]) * 43'(M_DIV125_HI);
	assign t_rhi  = hi_s1 - 21'(qhi_s1) * 21'd125;
	assign p_qlo  = 63'(x_s2) * 63'(M_DIV125_LO);
	assign t_r    = x_s3 - 31'(qlo_s3) * 31'd125;

	// seconds / 86400 as (secs >> 7) / 675; msec hundreds
	assign p_days = 64'(secs_s4[38:7]) * 64'(M_DIV675);
	assign p_mh   = 21'(msec_s4) * 21'(M_DIV100_MS);
	assign t_sodh = n2_s5 - 32'(days_s5) * 32'd675;
	assign t_ml   = msec_s5 - 10'(mh_s5) * 10'd100;

	// hour and era
	assign p_hour = 35'(sod_s6) * 35'(M_DIV3600);
	assign p_era  = 45'(z_s6) * 45'(M_DIV_ERA);
	assign t_remh = sod_s7 - 17'(tod_s7.hour) * 17'd3600;
	assign t_doe  = z_s7 - 22'(era_s7) * DAYS_PER_ERA;

	// minute and year-of-era terms
	assign p_min  = 25'(remh_s8) * 25'(M_DIV60);
	assign p_q1   = 37'(doe_s8) * 37'(M_DIV1460);
	assign p_q2   = 37'(doe_s8) * 37'(M_DIV36524);
	assign t_sec  = remh_s9 - 12'(tod_s9.minute) * 12'd60;
	assign p_yoe  = 37'(yy_s10) * 37'(M_DIV365);
	assign p_y100 = 19'(yoe_s11) * 19'(M_DIV100_Y);
	assign t_doy  = doe_s12 - (y365_s12 + 18'(yoe_s12[8:2]) - 18'(y100_s12));

	// month and day
	assign t_doy5 = {doy_s13, 2'b00} + 11'(doy_s13) + 11'd2;
	assign p_mp   = 23'(t_doy5) * 23'(M_DIV153);
	assign t_day  = doy_s14 - month_start(mp_s14) + 9'd1;
	assign t_mon  = (mp_s14 < 4'd10) ? mp_s14 + 4'd3 : mp_s14 - 4'd9;

	// year digits
	assign p_yh   = 29'(yw_s16) * 29'(M_DIV100_YR);
	assign t_yl   = yw_s17 - 14'(yh_s17) * 14'd100;

	// decimal digits for the last stage
	assign bcd_mon = to_bcd2(7'(month_s18));
	assign bcd_day = to_bcd2(7'(day_s18));
	assign bcd_hr  = to_bcd2(7'(tod_s18.hour));
	assign bcd_min = to_bcd2(7'(tod_s18.minute));
	assign bcd_sec = to_bcd2(7'(tod_s18.sec));
	assign bcd_ms  = to_bcd2(tod_s18.ml);
	assign bcd_yh  = to_bcd2(yh_s18);
	assign bcd_yl  = to_bcd2(yl_s18);

	// datapath, free running; vld_q marks live stages
	always_ff @(posedge clk) begin
		// s1
		hi_s1   <= item.millis[47:27];
		lo_s1   <= item.millis[26:3];
		m3_s1   <= item.millis[2:0];
		qhi_s1  <= p_qhi[42:28];
		bey_s1  <= item.beyond;
		// s2
		x_s2    <= {t_rhi[6:0], lo_s1};
		qhi_s2  <= qhi_s1;
		m3_s2   <= m3_s1;
		bey_s2  <= bey_s1;
		// s3
		qlo_s3  <= p_qlo[61:38];
		x_s3    <= x_s2;
		qhi_s3  <= qhi_s2;
		m3_s3   <= m3_s2;
		bey_s3  <= bey_s2;
		// s4
		msec_s4 <= {t_r[6:0], m3_s3};
		secs_s4 <= {qhi_s3, qlo_s3};
		bey_s4  <= bey_s3;
		// s5
		days_s5 <= p_days[62:41];
		n2_s5   <= secs_s4[38:7];
		s7_s5   <= secs_s4[6:0];
		mh_s5   <= p_mh[20:17];
		msec_s5 <= msec_s4;
		bey_s5  <= bey_s4;
		// s6
		sod_s6        <= {t_sodh[9:0], s7_s5};
		z_s6          <= days_s5 + DAYS_SHIFT;
		tod_s6        <= '{hour: 5'd0, minute: 6'd0, sec: 6'd0, mh: mh_s5,
			ml: t_ml[6:0], beyond: bey_s5};
		// s7
		tod_s7        <= '{hour: p_hour[33:29], minute: tod_s6.minute, sec: tod_s6.sec,
			mh: tod_s6.mh, ml: tod_s6.ml, beyond: tod_s6.beyond};
		era_s7        <= p_era[44:40];
		sod_s7        <= sod_s6;
		z_s7          <= z_s6;
		// s8
		tod_s8        <= tod_s7;
		remh_s8       <= t_remh[11:0];
		doe_s8        <= t_doe[17:0];
		era_s8        <= era_s7;
		// s9
		tod_s9        <= '{hour: tod_s8.hour, minute: p_min[23:18], sec: tod_s8.sec,
			mh: tod_s8.mh, ml: tod_s8.ml, beyond: tod_s8.beyond};
		q1_s9         <= p_q1[35:29];
		q2_s9         <= p_q2[36:34];
		q3_s9         <= (doe_s8 == DOE_LAST);
		remh_s9       <= remh_s8;
		doe_s9        <= doe_s8;
		era_s9        <= era_s8;
		// s10
		tod_s10       <= '{hour: tod_s9.hour, minute: tod_s9.minute, sec: t_sec[5:0],
			mh: tod_s9.mh, ml: tod_s9.ml, beyond: tod_s9.beyond};
		yy_s10        <= doe_s9 - 18'(q1_s9) + 18'(q2_s9) - 18'(q3_s9);
		doe_s10       <= doe_s9;
		era_s10       <= era_s9;
		// s11
		tod_s11       <= tod_s10;
		yoe_s11       <= p_yoe[35:27];
		doe_s11       <= doe_s10;
		era_s11       <= era_s10;
		// s12
		tod_s12       <= tod_s11;
		y100_s12      <= p_y100[17:16];
		y365_s12      <= 18'(yoe_s11) * 18'd365;
		yoe_s12       <= yoe_s11;
		doe_s12       <= doe_s11;
		era_s12       <= era_s11;
		// s13
		tod_s13       <= tod_s12;
		doy_s13       <= t_doy[8:0];
		yoe_s13       <= yoe_s12;
		era_s13       <= era_s12;
		// s14
		tod_s14       <= tod_s13;
		mp_s14        <= p_mp[22:19];
		doy_s14       <= doy_s13;
		yoe_s14       <= yoe_s13;
		era_s14       <= era_s13;
		// s15
		tod_s15       <= tod_s14;
		day_s15       <= t_day[4:0];
		month_s15     <= t_mon;
		year_s15      <= 14'(yoe_s14) + 14'(era_s14) * 14'd400 + 14'(t_mon <= 4'd2);
		// s16: years past 9999 keep their four low digits
		tod_s16       <= tod_s15;
		day_s16       <= day_s15;
		month_s16     <= month_s15;
		yw_s16        <= (year_s15 >= 14'd10000) ? year_s15 - 14'd10000 : year_s15;
		// s17
		tod_s17       <= tod_s16;
		day_s17       <= day_s16;
		month_s17     <= month_s16;
		yw_s17        <= yw_s16;
		yh_s17        <= p_yh[27:21];
		// s18
		tod_s18       <= tod_s17;
		day_s18       <= day_s17;
		month_s18     <= month_s17;
		yh_s18        <= yh_s17;
		yl_s18        <= t_yl[6:0];
		// s19: text assembly
		res_s19.w0 <= {digit_char(bcd_yh[7:4]), digit_char(bcd_yh[3:0]),
			digit_char(bcd_yl[7:4]), digit_char(bcd_yl[3:0]), CH_DASH,
			digit_char(bcd_mon[7:4]), digit_char(bcd_mon[3:0]), CH_DASH};
		res_s19.w1 <= {digit_char(bcd_day[7:4]), digit_char(bcd_day[3:0]), CH_T,
			digit_char(bcd_hr[7:4]), digit_char(bcd_hr[3:0]), CH_COLON,
			digit_char(bcd_min[7:4]), digit_char(bcd_min[3:0])};
		res_s19.w2 <= {CH_COLON, digit_char(bcd_sec[7:4]), digit_char(bcd_sec[3:0]),
			CH_DOT, digit_char(tod_s18.mh), digit_char(bcd_ms[7:4]),
			digit_char(bcd_ms[3:0]), CH_Z};
		res_s19.beyond <= tod_s18.beyond;
	end

	// issue only with a free result slot reserved
	assign issue    = item_valid && (credit_q < (OUT_AW+1)'(OUT_DEPTH));
	assign item_pop = issue;
	assign deq      = pop && !empty;
	assign empty    = (out_cnt_q == '0);
	assign result   = out_mem_q[out_rd_q];

	assign stat.credit_cnt = credit_q;
	assign stat.out_cnt    = out_cnt_q;

	// result queue storage
	always_ff @(posedge clk) begin
		if (vld_q[NSTAGE-1]) out_mem_q[out_wr_q] <= res_s19;
	end

	// valid chain, credits and result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			credit_q  <= '0;
			out_cnt_q <= '0;
			out_wr_q  <= '0;
			out_rd_q  <= '0;
		end else begin
			vld_q <= {vld_q[NSTAGE-2:0], issue};
			case ({issue, deq})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
			case ({vld_q[NSTAGE-1], deq})
				2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
				2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
				default: out_cnt_q <= out_cnt_q;
			endcase
			if (vld_q[NSTAGE-1]) out_wr_q <= out_wr_q + 1'b1;
			if (deq) out_rd_q <= out_rd_q + 1'b1;
		end
	end

endmodule

// ===== hdl/epoch_millis_to_iso8601_text.sv =====
// ----------------------------------------------------------------------------
// epoch_millis_to_iso8601_text
// Epoch milliseconds to the 24-character text YYYY-MM-DDTHH:MM:SS.mmmZ.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  input     | push / full        | millis_since_epoch[47:0]
//  result    | empty / pop        | text_chars_* (3 x 64), beyond_year_9999
//
//  One transaction per cycle sustained while results are popped; a result
//  reaches the ports through the front queue register, the 19-stage
//  reciprocal-multiply datapath, then the write into the result queue.
//  Reset clears the queues and the valid chain; no warm-up pass is needed.
//  A stalled result side fills the 32-entry result queue; the back stops
//  issuing when all credits are out, the front queue then fills and full rises.
// ----------------------------------------------------------------------------
`include "epoch_millis_to_iso8601_text_macros.svh"

module epoch_millis_to_iso8601_text (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [e2i_pkg::MILLIS_W-1:0]  millis_since_epoch,
	output logic                          empty,
	input  logic                          pop,
	output logic [e2i_pkg::WORD_W-1:0]    text_chars_0_to_7,
	output logic [e2i_pkg::WORD_W-1:0]    text_chars_8_to_15,
	output logic [e2i_pkg::WORD_W-1:0]    text_chars_16_to_23,
	output logic                          beyond_year_9999
);
	import e2i_pkg::*;

	logic        item_valid;
	logic        item_pop;
	e2i_item_t   item;
	e2i_result_t result;
	e2i_stat_t   stat;

	e2i_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.millis_since_epoch (millis_since_epoch),
		.item_valid         (item_valid),
		.item               (item),
		.item_pop           (item_pop)
	);

	e2i_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result),
		.stat       (stat)
	);

	assign text_chars_0_to_7   = result.w0;
	assign text_chars_8_to_15  = result.w1;
	assign text_chars_16_to_23 = result.w2;
	assign beyond_year_9999    = result.beyond;

	// credits never exceed the result queue depth
	`E2I_ASSERT_NEVER(a_credit_cap, clk, arst_n, stat.credit_cnt > (OUT_AW+1)'(OUT_DEPTH))
	// queued results are always covered by credits
	`E2I_ASSERT_NEVER(a_out_le_credit, clk, arst_n, stat.out_cnt > stat.credit_cnt)
	// a waiting item with a free credit is always taken
	`E2I_ASSERT_IMPLY(a_no_stall, clk, arst_n, item_valid && (stat.credit_cnt < (OUT_AW+1)'(OUT_DEPTH)), item_pop)

endmodule
